// ===== rtl/core/tpcr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpcr_pkg
// Shared types and constants for the two-phase current reference: the Q15
// sine table, phase geometry and the int16 scaling constants.
// ----------------------------------------------------------------------------
package tpcr_pkg;

    // Sine table geometry
    localparam int TBL_BITS  = 5;
    localparam int TBL_DEPTH = 1 << TBL_BITS;
    localparam int PHASE_W   = 32;
    localparam int SAMPLE_W  = 16;

    typedef logic [PHASE_W-1:0]         phase_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [TBL_BITS-1:0]        tbl_idx_t;

    // Quarter turn for the cosine path
    localparam phase_t QUARTER_TURN = 32'h4000_0000;

    // Q15 scaling: divide by 2^15 - 1 with half-scale rounding
    localparam int      Q15_BITS  = 15;
    localparam sample_t Q15_SCALE = 16'sd32767;
    localparam sample_t Q15_HALF  = 16'sd16383;

    // Saturation limits of the result
    localparam sample_t SAT_HI = 16'sh7FFF;
    localparam sample_t SAT_LO = 16'sh8000;

    // One full period of sine in Q15, 32 entries
    localparam sample_t SINE_TAB [TBL_DEPTH] = '{
        16'sd0,      16'sd6393,   16'sd12539,  16'sd18204,
        16'sd23170,  16'sd27245,  16'sd30273,  16'sd32137,
        16'sd32767,  16'sd32137,  16'sd30273,  16'sd27245,
        16'sd23170,  16'sd18204,  16'sd12539,  16'sd6393,
        16'sd0,     -16'sd6393,  -16'sd12539, -16'sd18204,
       -16'sd23170, -16'sd27245, -16'sd30273, -16'sd32137,
       -16'sd32767, -16'sd32137, -16'sd30273, -16'sd27245,
       -16'sd23170, -16'sd18204, -16'sd12539, -16'sd6393
    };

endpackage

// ===== rtl/core/two_phase_current_reference.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_phase_current_reference
// Polar current command to two-phase references: A = magnitude * cos(phase),
// B = magnitude * sin(phase), from an interpolated Q15 sine table.
// ----------------------------------------------------------------------------
//  Channel  | Handshake             | Payload
//  ---------+-----------------------+--------------------------------------
//  input    | in_valid / in_ready   | magnitude[15:0] s, phase[31:0] u
//  output   | out_valid / out_ready | current_a[15:0] s, current_b[15:0] s
//
//  Six register stages: three for the sine (lookup, slope multiply, shift and
//  add) and three for scaling (product, rounding and reduction, saturation).
//  One request per cycle while the output is not stalled; out_valid rises
//  once the request has passed all six register stages.
//  The whole pipeline advances when the output register is empty or taken,
//  so a stall freezes every stage and nothing is lost or repeated.
//  Reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
module two_phase_current_reference #(
    parameter int INTERP_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tpcr_pkg::sample_t magnitude,
    input  tpcr_pkg::phase_t  phase,
    output logic              out_valid,
    input  logic              out_ready,
    output tpcr_pkg::sample_t current_a,
    output tpcr_pkg::sample_t current_b
);
    import tpcr_pkg::*;

    localparam int SINE_STAGES  = 3;
    localparam int SCALE_STAGES = 3;
    localparam int DEPTH        = SINE_STAGES + SCALE_STAGES;

    logic             en;
    logic [DEPTH-1:0] vld_reg, vld_next;
    sample_t          mag_reg [SINE_STAGES];
    phase_t           phase_cos;
    sample_t          sin_a;
    sample_t          sin_b;

    // Advance when the output slot is free or being drained
    assign en       = out_ready || !vld_reg[DEPTH-1];
    assign in_ready = en;

    // Shift valid bits along with the data
    always_comb
    begin
        vld_next = {vld_reg[DEPTH-2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    // Delay the magnitude to meet the sine results
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg[0] <= magnitude;
            for (int i = 1; i < SINE_STAGES; i++)
                mag_reg[i] <= mag_reg[i-1];
        end
    end

    // Cosine is the sine a quarter turn ahead
    assign phase_cos = phase + QUARTER_TURN;

    tpcr_sine #(
        .INTERP_BITS (INTERP_BITS)
    ) u_sine_a (
        .clk   (clk),
        .en    (en),
        .phase (phase_cos),
        .sine  (sin_a)
    );

    tpcr_sine #(
        .INTERP_BITS (INTERP_BITS)
    ) u_sine_b (
        .clk   (clk),
        .en    (en),
        .phase (phase),
        .sine  (sin_b)
    );

    tpcr_scale u_scale_a (
        .clk    (clk),
        .en     (en),
        .q15    (sin_a),
        .mag    (mag_reg[SINE_STAGES-1]),
        .result (current_a)
    );

    tpcr_scale u_scale_b (
        .clk    (clk),
        .en     (en),
        .q15    (sin_b),
        .mag    (mag_reg[SINE_STAGES-1]),
        .result (current_b)
    );

    assign out_valid = vld_reg[DEPTH-1];

endmodule

// ===== rtl/core/tpcr_sine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpcr_sine
// Three-stage interpolated sine: table lookup, slope times fraction, then
// floor shift and add to the base entry.
// ----------------------------------------------------------------------------
module tpcr_sine #(
    parameter int INTERP_BITS = 16
) (
    input  logic             clk,
    input  logic             en,
    input  tpcr_pkg::phase_t phase,
    output tpcr_pkg::sample_t sine
);
    import tpcr_pkg::*;

    localparam int PROD_W = SAMPLE_W + INTERP_BITS + 1;

    // Stage 1: lookup
    tbl_idx_t               idx;
    tbl_idx_t               nxt;
    sample_t                base_s1_reg, base_s1_next;
    sample_t                diff_reg, diff_next;
    logic [INTERP_BITS-1:0] frac_reg, frac_next;

    // Stage 2: slope times fraction
    sample_t                  base_s2_reg;
    logic signed [PROD_W-1:0] prod_reg, prod_next;

    // Stage 3: shift and add
    logic signed [PROD_W-1:0] step_w;
    sample_t                  sine_reg, sine_next;

    // Select the entry pair and fraction
    always_comb
    begin
        idx          = phase[PHASE_W-1 -: TBL_BITS];
        nxt          = idx + tbl_idx_t'(1);
        base_s1_next = SINE_TAB[idx];
        diff_next    = SINE_TAB[nxt] - SINE_TAB[idx];
        frac_next    = phase[PHASE_W-1-TBL_BITS -: INTERP_BITS];
    end

    // Scale the slope by the fraction
    always_comb
    begin
        prod_next = diff_reg * $signed({1'b0, frac_reg});
    end

    // Floor shift and add the base
    always_comb
    begin
        step_w    = prod_reg >>> INTERP_BITS;
        sine_next = base_s2_reg + $signed(step_w[SAMPLE_W-1:0]);
    end

    // Advance all stages together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            base_s1_reg <= base_s1_next;
            diff_reg    <= diff_next;
            frac_reg    <= frac_next;
            base_s2_reg <= base_s1_reg;
            prod_reg    <= prod_next;
            sine_reg    <= sine_next;
        end
    end

    assign sine = sine_reg;

endmodule

// ===== rtl/core/tpcr_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpcr_scale
// Three-stage Q15 scaling: product, rounding and first reduction by
// 2^15 - 1, then final correction, sign and int16 saturation.
// ----------------------------------------------------------------------------
module tpcr_scale (
    input  logic              clk,
    input  logic              en,
    input  tpcr_pkg::sample_t q15,
    input  tpcr_pkg::sample_t mag,
    output tpcr_pkg::sample_t result
);
    import tpcr_pkg::*;

    localparam int PROD_W = 2 * SAMPLE_W;
    localparam int ABS_W  = 2 * Q15_BITS;
    localparam int QUO_W  = Q15_BITS + 2;

    // Stage 1: product
    logic signed [PROD_W-1:0] prod_reg, prod_next;

    // Stage 2: magnitude plus rounding, first reduction
    logic [PROD_W-1:0]   abs_w;
    logic [ABS_W-1:0]    rnd_w;
    logic                neg_reg, neg_next;
    logic [Q15_BITS-1:0] q1_reg, q1_next;
    logic [SAMPLE_W-1:0] rem_reg, rem_next;

    // Stage 3: correction, sign, saturation
    logic                q2_w;
    logic [SAMPLE_W-1:0] rem2_w;
    logic                fix_w;
    logic [QUO_W-1:0]    quo_w;
    logic [QUO_W-1:0]    quo_neg_w;
    sample_t             result_reg, result_next;

    // Form the full product
    always_comb
    begin
        prod_next = q15 * mag;
    end

    // Round the magnitude to nearest; split x / (2^15 - 1) as x >> 15 plus a remainder
    always_comb
    begin
        neg_next = prod_reg[PROD_W-1];
        abs_w    = neg_next ? (-prod_reg) : prod_reg;
        rnd_w    = abs_w[ABS_W-1:0] + ABS_W'(Q15_HALF);
        q1_next  = rnd_w[ABS_W-1 -: Q15_BITS];
        rem_next = {1'b0, rnd_w[Q15_BITS-1:0]} + {1'b0, q1_next};
    end

    // Finish the quotient, restore the sign, clamp to int16
    always_comb
    begin
        q2_w      = rem_reg[SAMPLE_W-1];
        rem2_w    = {1'b0, rem_reg[Q15_BITS-1:0]} + SAMPLE_W'(q2_w);
        fix_w     = (rem2_w >= Q15_SCALE);
        quo_w     = {2'b00, q1_reg} + QUO_W'(q2_w) + QUO_W'(fix_w);
        quo_neg_w = -quo_w;
        if (!neg_reg)
        begin
            if (quo_w > QUO_W'(SAT_HI))
                result_next = SAT_HI;
            else
                result_next = quo_w[SAMPLE_W-1:0];
        end
        else
        begin
            if (quo_w > {1'b0, SAT_LO})
                result_next = SAT_LO;
            else
                result_next = quo_neg_w[SAMPLE_W-1:0];
        end
    end

    // Advance all stages together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg   <= prod_next;
            neg_reg    <= neg_next;
            q1_reg     <= q1_next;
            rem_reg    <= rem_next;
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule
